// ===== rtl/core/crmt_pkg.sv =====
// Package for the CAN receive mailbox table: mailbox record type, status codes
// and identifier limits. Used by every module under rtl/core; depends on nothing.
package crmt_pkg;

  localparam int MAILBOXES_DEF = 16;
  localparam int BUSES_DEF     = 2;

  localparam logic [28:0] STD_ID_MAX = 29'h7FF;
  localparam logic [3:0]  DLC_MAX    = 4'd8;

  localparam logic [2:0] ST_REJECTED   = 3'd0;
  localparam logic [2:0] ST_FOUND_RX   = 3'd1;
  localparam logic [2:0] ST_FOUND_NONE = 3'd2;
  localparam logic [2:0] ST_SUBSCRIBED = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_STORED     = 3'd5;
  localparam logic [2:0] ST_UNMATCHED  = 3'd6;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // One mailbox: its key, its latest frame and its sequence count.
  typedef struct packed {
    logic        used;
    logic [28:0] key_id;
    logic        key_ext;
    logic [28:0] frame_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] seq;
  } crmt_slot_t;

endpackage

// ===== rtl/core/crmt_cell.sv =====
// One mailbox cell of the rotating chain: holds a mailbox record and takes its
// neighbor's record whenever the chain advances. Depends on crmt_pkg.
module crmt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  crmt_pkg::crmt_slot_t   slot_i,
  output crmt_pkg::crmt_slot_t   slot_o
);
  import crmt_pkg::*;

  crmt_slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (load_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/core/crmt_ring.sv =====
// Mailbox chain of one bus: MAILBOXES cells that rotate one place per advance,
// the head cell feeding the compare logic and the tail taking its result back.
// Depends on crmt_pkg and crmt_cell.
module crmt_ring #(
  parameter int MAILBOXES = crmt_pkg::MAILBOXES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  crmt_pkg::crmt_slot_t   tail_i,
  output crmt_pkg::crmt_slot_t   head_o
);
  import crmt_pkg::*;

  crmt_slot_t cell_q [MAILBOXES];
  crmt_slot_t cell_d [MAILBOXES];

  for (genvar i = 0; i < MAILBOXES; i++) begin : g_cell
    if (i == MAILBOXES - 1) begin : g_tail
      assign cell_d[i] = tail_i;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end

    crmt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (shift_i),
      .slot_i (cell_d[i]),
      .slot_o (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== rtl/core/can_rx_mailbox_table.sv =====
// CAN receive mailbox table: one chain of mailbox cells per bus, a sequencer that
// rotates the addressed chain past a compare stage, and the APB enable register.
// Depends on crmt_pkg and crmt_ring.
//
// A request is taken when start is high and busy is low. Each bus chain
// advances one mailbox per cycle past a single compare stage; a store or a query
// that reaches the table registers the request, passes every mailbox by the
// compare stage and then presents the result. A query rejected by its bus, enable
// or id check, or a store with a bad bus or byte count, goes straight from the
// registered request to the result. The result appears for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must take it then. All
// mailboxes are cleared directly by reset; no clearing pass follows reset.
module can_rx_mailbox_table #(
  parameter int MAILBOXES = crmt_pkg::MAILBOXES_DEF,
  parameter int BUSES     = crmt_pkg::BUSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic        bus_i,
  input  logic [28:0] frame_id_i,
  input  logic        ext_i,
  input  logic [3:0]  dlc_i,
  input  logic [63:0] payload_i,
  // result side
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [28:0] out_id_o,
  output logic        out_ext_o,
  output logic [3:0]  out_dlc_o,
  output logic [63:0] out_payload_o,
  output logic [31:0] out_seq_o
);
  import crmt_pkg::*;

  localparam int CW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  localparam logic [1:0] REG_BUS_ENABLE = 2'd0;

  // Configuration register.
  logic [1:0] bus_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_enable_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_BUS_ENABLE)) begin
      bus_enable_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {30'b0, bus_enable_q};

  // Request registers
  logic [1:0]    state_q;
  logic [CW-1:0] cnt_q;
  logic          hit_q;
  logic          req_q;
  logic          bus_q;
  logic [28:0]   id_q;
  logic          ext_q;
  logic [3:0]    dlc_q;
  logic [63:0]   payload_q;

  logic [2:0]    res_status_q;
  logic [28:0]   res_id_q;
  logic          res_ext_q;
  logic [3:0]    res_dlc_q;
  logic [63:0]   res_payload_q;
  logic [31:0]   res_seq_q;

  logic accept;
  logic bus_ok;
  logic pre_reject;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign bus_ok = (32'(bus_i) < 32'(BUSES));

  always_comb begin
    if (req_type_i == REQ_STORE) begin
      pre_reject = !bus_ok || (dlc_i > DLC_MAX);
    end else begin
      pre_reject = !bus_ok || !bus_enable_q[bus_i] ||
                   (!ext_i && (frame_id_i > STD_ID_MAX));
    end
  end

  // Chains and head compare
  crmt_slot_t head   [BUSES];
  logic       shift  [BUSES];
  crmt_slot_t sel_head;
  crmt_slot_t new_slot;
  logic       match;
  logic       act;

  always_comb begin
    sel_head = head[0];
    for (int b = 0; b < BUSES; b++) begin
      if (bus_q == 1'(b)) begin
        sel_head = head[b];
      end
    end
  end

  assign match = sel_head.used && (sel_head.key_id == id_q) && (sel_head.key_ext == ext_q);

  // Subscription only ever takes the lowest free mailbox and never releases one,
  // so used mailboxes form a prefix of the chain: the first free one seen on a
  // query means no match can follow it.
  always_comb begin
    new_slot = sel_head;
    act      = 1'b0;
    if (!hit_q) begin
      if (req_q == REQ_STORE) begin
        if (match) begin
          act               = 1'b1;
          new_slot.frame_id = id_q;
          new_slot.dlc      = dlc_q;
          new_slot.payload  = payload_q;
          new_slot.seq      = sel_head.seq + 32'd1;
        end
      end else begin
        if (match) begin
          act = 1'b1;
        end else if (!sel_head.used) begin
          act               = 1'b1;
          new_slot.used     = 1'b1;
          new_slot.key_id   = id_q;
          new_slot.key_ext  = ext_q;
          new_slot.frame_id = id_q;
        end
      end
    end
  end

  for (genvar b = 0; b < BUSES; b++) begin : g_bus
    assign shift[b] = (state_q == S_SCAN) && (bus_q == 1'(b));

    crmt_ring #(
      .MAILBOXES (MAILBOXES)
    ) u_ring (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift[b]),
      .tail_i  (new_slot),
      .head_o  (head[b])
    );
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      res_status_q <= ST_REJECTED;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            hit_q <= 1'b0;
            if (pre_reject) begin
              res_status_q <= (req_type_i == REQ_STORE) ? ST_UNMATCHED : ST_REJECTED;
              state_q      <= S_REPORT;
            end else begin
              res_status_q <= ST_REJECTED;
              state_q      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (act) begin
            hit_q <= 1'b1;
            if (req_q == REQ_STORE) begin
              res_status_q <= ST_STORED;
            end else if (!match) begin
              res_status_q <= ST_SUBSCRIBED;
            end else if (sel_head.seq != 32'd0) begin
              res_status_q <= ST_FOUND_RX;
            end else begin
              res_status_q <= ST_FOUND_NONE;
            end
          end
          if (cnt_q == CW'(MAILBOXES - 1)) begin
            state_q <= S_REPORT;
            if (!hit_q && !act) begin
              res_status_q <= (req_q == REQ_STORE) ? ST_UNMATCHED : ST_FULL;
            end
          end
        end
        S_REPORT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q         <= req_type_i;
      bus_q         <= bus_i;
      id_q          <= frame_id_i;
      ext_q         <= ext_i;
      dlc_q         <= dlc_i;
      payload_q     <= payload_i;
      res_id_q      <= '0;
      res_ext_q     <= 1'b0;
      res_dlc_q     <= '0;
      res_payload_q <= '0;
      res_seq_q     <= '0;
    end else if ((state_q == S_SCAN) && act && (req_q == REQ_QUERY) && match) begin
      res_id_q      <= sel_head.frame_id;
      res_ext_q     <= sel_head.key_ext;
      res_dlc_q     <= sel_head.dlc;
      res_payload_q <= sel_head.payload;
      res_seq_q     <= sel_head.seq;
    end
  end

  assign done_o        = (state_q == S_REPORT);
  assign status_o      = res_status_q;
  assign out_id_o      = res_id_q;
  assign out_ext_o     = res_ext_q;
  assign out_dlc_o     = res_dlc_q;
  assign out_payload_o = res_payload_q;
  assign out_seq_o     = res_seq_q;

endmodule
